>>> sv/mrt_pkg.sv
// mrt_pkg: shared types and constants of the route table engine
// depends on nothing
package mrt_pkg;

  localparam logic [3:0] OP_UPD_NOSEQ = 4'd0;
  localparam logic [3:0] OP_UPD_SEQ   = 4'd1;
  localparam logic [3:0] OP_LOOKUP    = 4'd2;
  localparam logic [3:0] OP_ADD_LIFE  = 4'd3;
  localparam logic [3:0] OP_USED      = 4'd4;
  localparam logic [3:0] OP_RERR      = 4'd5;
  localparam logic [3:0] OP_TICK      = 4'd6;
  localparam logic [3:0] OP_INC_OWN   = 4'd7;
  localparam logic [3:0] OP_UPD_OWN   = 4'd8;
  localparam logic [3:0] OP_BY_NH     = 4'd9;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [1:0] CFG_MY_IP  = 2'd0;
  localparam logic [1:0] CFG_ACTIVE = 2'd1;
  localparam logic [1:0] CFG_DELETE = 2'd2;

  localparam int MAX_RESULTS = 16;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] dest_addr;
    logic [31:0] source_addr;
    logic [31:0] next_hop;
    logic [31:0] seq_num;
    logic [7:0]  hop_count;
    logic [30:0] lifetime_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        present;
    logic        valid_res;
    logic        seq_known;
    logic [31:0] out_dest;
    logic [31:0] out_next_hop;
    logic [31:0] out_seq;
    logic [7:0]  out_hops;
    logic [30:0] life_left_ms;
    logic [31:0] own_seq;
    logic        route_written;
    logic        last;
  } res_t;

  // strictly later in wrapping 32-bit space
  function automatic logic is_later(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

>>> sv/mrt_if.sv
// mrt_if: valid/ready channel carrying one payload
// depends on mrt_pkg for payload types
interface mrt_req_if;
  logic          valid;
  logic          ready;
  mrt_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mrt_res_if;
  logic          valid;
  logic          ready;
  mrt_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/manet_route_table_engine_top.sv
// Route table engine: TableEntries slots searched one per cycle while no result waits
// on the output, one operation at a time. Own-sequence, ignored and unused ops need no
// scan; a lookup, extend or route error makes one key scan, a tick one pass over all
// slots, an insert into a new slot a key scan then a free-slot scan, op 4 up to three
// key scans and op 9 one next-hop scan that pauses at each reported route. The
// sequential slot scan in mrt_ctrl sets this work; an output stall holds it until the
// result is taken.
// depends on mrt_pkg, mrt_if, mrt_ctrl and mrt_datapath
module manet_route_table_engine_top #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  mrt_req_if.sink     in_ch,
  mrt_res_if.source   out_ch
);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic load, key_hit, slot_free, nh_hit, accept_upd, mine, src_mine;
  logic do_write, do_refresh, do_life, do_rerr, do_tick_now, do_tick_ent, do_own;
  logic [IW-1:0] scan_idx, sel;
  logic [1:0] key_sel;
  mrt_pkg::res_t form;

  mrt_ctrl #(.TableEntries(TABLE_ENTRIES)) u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.data.op),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .load, .scan_idx, .key_sel, .do_write, .do_refresh, .do_life, .do_rerr,
    .do_tick_now, .do_tick_ent, .do_own, .sel, .key_hit, .slot_free, .nh_hit,
    .accept_upd, .mine, .src_mine, .form
  );

  mrt_datapath #(.TableEntries(TABLE_ENTRIES)) u_dp (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data, .req(in_ch.data), .load,
    .scan_idx, .key_sel, .do_write, .do_refresh, .do_life, .do_rerr,
    .do_tick_now, .do_tick_ent, .do_own, .sel, .key_hit, .slot_free, .nh_hit,
    .accept_upd, .mine, .src_mine, .form
  );
endmodule

>>> sv/mrt_datapath.sv
// mrt_datapath: route table storage, scan compare and result formation
// depends on mrt_pkg; driven by mrt_ctrl commands
module mrt_datapath #(
  parameter int TableEntries = 16,
  parameter int IW = (TableEntries > 1) ? $clog2(TableEntries) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [31:0]      cfg_data,
  input  mrt_pkg::req_t    req,
  input  logic             load,       // capture request
  input  logic [IW-1:0]    scan_idx,
  input  logic [1:0]       key_sel,    // 0 dest 1 source 2 stored next hop
  input  logic             do_write,   // perform update at sel
  input  logic             do_refresh,
  input  logic             do_life,
  input  logic             do_rerr,
  input  logic             do_tick_now,
  input  logic             do_tick_ent,
  input  logic             do_own,
  input  logic [IW-1:0]    sel,
  output logic             key_hit,
  output logic             slot_free,
  output logic             nh_hit,
  output logic             accept_upd,
  output logic             mine,
  output logic             src_mine,
  output mrt_pkg::res_t    form      // result fields for entry sel
);
  logic [31:0] my_ip;
  logic [30:0] active_ms, delete_ms;
  logic [31:0] now_ms, own_seq;
  mrt_pkg::req_t r;
  logic [TableEntries-1:0] used, vld;
  logic        sv_f [TableEntries];
  logic [31:0] dst [TableEntries];
  logic [31:0] nhp [TableEntries];
  logic [31:0] sq [TableEntries];
  logic [7:0]  hp [TableEntries];
  logic [31:0] exp_t [TableEntries];
  logic [31:0] key, left, life_sel, active_exp;

  // config and request capture
  always_ff @(posedge clk) begin
    if (rst) begin
      my_ip <= 32'd0;
      active_ms <= 31'd3000;
      delete_ms <= 31'd15000;
    end else if (cfg_we) begin
      case (cfg_idx)
        mrt_pkg::CFG_MY_IP:  my_ip <= cfg_data;
        mrt_pkg::CFG_ACTIVE: active_ms <= cfg_data[30:0];
        mrt_pkg::CFG_DELETE: delete_ms <= cfg_data[30:0];
        default: ;
      endcase
    end
    if (load) r <= req;
  end

  always_comb begin
    case (key_sel)
      2'd1:    key = r.source_addr;
      2'd2:    key = nhp[sel];
      default: key = r.dest_addr;
    endcase
  end

  assign key_hit = used[scan_idx] && (dst[scan_idx] == key);
  assign slot_free = !used[scan_idx];
  assign nh_hit = used[scan_idx] && vld[scan_idx] && (nhp[scan_idx] == r.next_hop);
  assign mine = (r.dest_addr == my_ip) || (r.next_hop == my_ip);
  assign src_mine = (r.source_addr == my_ip);
  assign accept_upd = (r.op == mrt_pkg::OP_UPD_NOSEQ) || !vld[sel] ||
                      mrt_pkg::is_later(r.seq_num, sq[sel]) ||
                      ((r.seq_num == sq[sel]) && (r.hop_count < hp[sel]));
  assign life_sel = (r.op == mrt_pkg::OP_UPD_SEQ && r.lifetime_ms != 31'd0) ?
                    {1'b0, r.lifetime_ms} : {1'b0, active_ms};
  assign active_exp = now_ms + {1'b0, active_ms};

  // table state
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      vld <= '0;
      now_ms <= 32'd0;
      own_seq <= 32'd0;
    end else begin
      if (do_write) begin
        used[sel] <= 1'b1;
        vld[sel] <= 1'b1;
      end
      if (do_refresh) vld[sel] <= 1'b1;
      if (do_rerr) vld[sel] <= 1'b0;
      if (do_tick_now) now_ms <= now_ms + 32'd1;
      if (do_tick_ent && used[scan_idx] && !mrt_pkg::is_later(exp_t[scan_idx], now_ms)) begin
        if (vld[scan_idx]) vld[scan_idx] <= 1'b0;
        else used[scan_idx] <= 1'b0;
      end
      if (do_own) begin
        if (r.op == mrt_pkg::OP_INC_OWN) own_seq <= own_seq + 32'd1;
        else if (!mrt_pkg::is_later(own_seq, r.seq_num)) own_seq <= r.seq_num;
      end
    end
  end

  // entry payload, no reset
  always_ff @(posedge clk) begin
    if (do_write) begin
      sv_f[sel] <= (r.op == mrt_pkg::OP_UPD_SEQ);
      dst[sel] <= r.dest_addr;
      nhp[sel] <= r.next_hop;
      sq[sel] <= (r.op == mrt_pkg::OP_UPD_SEQ) ? r.seq_num : 32'd0;
      hp[sel] <= r.hop_count;
      exp_t[sel] <= now_ms + life_sel;
    end
    if (do_refresh && mrt_pkg::is_later(active_exp, exp_t[sel])) exp_t[sel] <= active_exp;
    if (do_life && mrt_pkg::is_later(now_ms + {1'b0, r.lifetime_ms}, exp_t[sel]))
      exp_t[sel] <= now_ms + {1'b0, r.lifetime_ms};
    if (do_rerr) begin
      if (vld[sel]) sq[sel] <= sq[sel] + 32'd1;
      exp_t[sel] <= now_ms + {1'b0, delete_ms};
    end
    if (do_tick_ent && used[scan_idx] && vld[scan_idx] &&
        !mrt_pkg::is_later(exp_t[scan_idx], now_ms))
      exp_t[scan_idx] <= now_ms + {1'b0, delete_ms};
  end

  // result fields of selected entry
  always_comb begin
    left = exp_t[sel] - now_ms;
    if (left == 32'd0 || left[31]) left = 32'd1;
    form = '0;
    form.present = 1'b1;
    form.valid_res = vld[sel];
    form.seq_known = sv_f[sel];
    form.out_dest = dst[sel];
    form.out_next_hop = nhp[sel];
    form.out_seq = sq[sel];
    form.out_hops = hp[sel];
    form.life_left_ms = left[30:0];
    form.own_seq = own_seq;
  end
endmodule

>>> sv/mrt_ctrl.sv
// mrt_ctrl: sequencer for table scans and result transfers
// depends on mrt_pkg and mrt_datapath status
module mrt_ctrl #(
  parameter int TableEntries = 16,
  parameter int IW = (TableEntries > 1) ? $clog2(TableEntries) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [3:0]       in_op,
  output logic             out_valid,
  input  logic             out_ready,
  output mrt_pkg::res_t    out_data,
  output logic             load,
  output logic [IW-1:0]    scan_idx,
  output logic [1:0]       key_sel,
  output logic             do_write,
  output logic             do_refresh,
  output logic             do_life,
  output logic             do_rerr,
  output logic             do_tick_now,
  output logic             do_tick_ent,
  output logic             do_own,
  output logic [IW-1:0]    sel,
  input  logic             key_hit,
  input  logic             slot_free,
  input  logic             nh_hit,
  input  logic             accept_upd,
  input  logic             mine,
  input  logic             src_mine,
  input  mrt_pkg::res_t    form
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_FIND = 4'd2, S_FREE = 4'd3,
                         S_ACT = 4'd4, S_EMIT = 4'd5, S_OUT = 4'd6, S_TICK = 4'd7,
                         S_NHS = 4'd8, S_INS = 4'd9;
  localparam logic [IW-1:0] LastIdx = IW'(TableEntries - 1);

  logic [3:0]    state;
  logic [IW-1:0] idx;
  logic [3:0]    op;
  logic [1:0]    phase;     // op 4: 0 source 1 dest 2 next hop
  logic          found, pend;
  logic [IW-1:0] dest_sel;
  logic [4:0]    count;
  logic [1:0]    st;
  logic          wr, use_ent, fin, upd_op;
  mrt_pkg::res_t res, emit_res;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign load = in_valid && in_ready;
  assign scan_idx = idx;
  assign upd_op = (op == mrt_pkg::OP_UPD_NOSEQ) || (op == mrt_pkg::OP_UPD_SEQ);
  assign key_sel = (op == mrt_pkg::OP_USED) ? ((phase == 2'd0) ? 2'd1 :
                   (phase == 2'd2) ? 2'd2 : 2'd0) : 2'd0;
  assign do_tick_ent = (state == S_TICK);
  assign do_tick_now = (state == S_DISP) && (op == mrt_pkg::OP_TICK);
  assign do_own = (state == S_DISP) && (op == mrt_pkg::OP_INC_OWN || op == mrt_pkg::OP_UPD_OWN);
  assign out_valid = (state == S_OUT);
  assign out_data = res;

  // one-shot entry actions in S_ACT and insert into a free slot
  always_comb begin
    do_write = 1'b0; do_refresh = 1'b0; do_life = 1'b0; do_rerr = 1'b0;
    if (state == S_INS) begin
      do_write = 1'b1;
    end else if (state == S_ACT && found) begin
      case (op)
        mrt_pkg::OP_UPD_NOSEQ, mrt_pkg::OP_UPD_SEQ: do_write = accept_upd;
        mrt_pkg::OP_ADD_LIFE: do_life = 1'b1;
        mrt_pkg::OP_RERR:     do_rerr = 1'b1;
        mrt_pkg::OP_USED:     do_refresh = 1'b1;
        default: ;
      endcase
    end
  end

  // result word, entry fields only when an entry is reported
  always_comb begin
    emit_res = use_ent ? form : '0;
    emit_res.own_seq = form.own_seq;
    emit_res.status = st;
    emit_res.route_written = wr;
    emit_res.last = fin;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      phase <= 2'd0;
      found <= 1'b0;
      pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (load) begin
          op <= in_op;
          state <= S_DISP;
        end
        S_DISP: begin
          idx <= '0; found <= 1'b0; pend <= 1'b0; count <= 5'd0;
          wr <= 1'b0; use_ent <= 1'b0;
          // source refresh is skipped when the source is this node
          phase <= (op == mrt_pkg::OP_USED && src_mine) ? 2'd1 : 2'd0;
          fin <= (op != mrt_pkg::OP_BY_NH);
          st <= (upd_op && mine) ? mrt_pkg::ST_NOTFOUND : mrt_pkg::ST_OK;
          case (op)
            mrt_pkg::OP_UPD_NOSEQ, mrt_pkg::OP_UPD_SEQ: state <= mine ? S_EMIT : S_FIND;
            mrt_pkg::OP_LOOKUP, mrt_pkg::OP_ADD_LIFE, mrt_pkg::OP_RERR,
            mrt_pkg::OP_USED: state <= S_FIND;
            mrt_pkg::OP_TICK: state <= S_TICK;
            mrt_pkg::OP_BY_NH: state <= S_NHS;
            default: state <= S_EMIT;
          endcase
        end
        S_FIND: begin
          if (key_hit) begin
            sel <= idx; found <= 1'b1; idx <= '0; state <= S_ACT;
          end else if (idx == LastIdx) begin
            idx <= '0; found <= 1'b0; state <= S_ACT;
          end else idx <= idx + 1'b1;
        end
        S_FREE: begin
          if (slot_free) begin
            sel <= idx; state <= S_INS;
          end else if (idx == LastIdx) begin
            st <= mrt_pkg::ST_FULL; state <= S_EMIT;
          end else idx <= idx + 1'b1;
        end
        S_INS: begin
          wr <= 1'b1; use_ent <= 1'b1; state <= S_EMIT;
        end
        S_ACT: begin
          case (op)
            mrt_pkg::OP_UPD_NOSEQ, mrt_pkg::OP_UPD_SEQ: begin
              if (found) begin
                wr <= accept_upd; use_ent <= 1'b1; state <= S_EMIT;
              end else begin
                idx <= '0; state <= S_FREE;
              end
            end
            mrt_pkg::OP_USED: begin
              // source, then destination, then the destination's next hop
              if (phase == 2'd0) begin
                phase <= 2'd1; state <= S_FIND; found <= 1'b0;
              end else if (phase == 2'd1) begin
                use_ent <= found;
                st <= found ? mrt_pkg::ST_OK : mrt_pkg::ST_NOTFOUND;
                if (found) begin
                  dest_sel <= sel; phase <= 2'd2; state <= S_FIND; found <= 1'b0;
                end else state <= S_EMIT;
              end else begin
                // report the destination entry
                sel <= dest_sel; state <= S_EMIT;
              end
            end
            default: begin
              use_ent <= found;
              st <= found ? mrt_pkg::ST_OK : mrt_pkg::ST_NOTFOUND;
              state <= S_EMIT;
            end
          endcase
        end
        S_EMIT: begin
          res <= emit_res;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          if (fin) state <= S_IDLE;
          else begin
            // pending match at idx becomes the next reported entry
            count <= count + 5'd1;
            sel <= idx;
            if (idx == LastIdx || count == 5'(mrt_pkg::MAX_RESULTS - 2)) begin
              fin <= 1'b1; state <= S_EMIT;
            end else begin
              idx <= idx + 1'b1; state <= S_NHS;
            end
          end
        end
        S_TICK: begin
          if (idx == LastIdx) state <= S_EMIT;
          else idx <= idx + 1'b1;
        end
        S_NHS: begin
          // one match is held back so that the final one carries last
          if (nh_hit) begin
            if (pend) begin
              state <= S_EMIT;
            end else begin
              sel <= idx; use_ent <= 1'b1; pend <= 1'b1;
              if (idx == LastIdx) begin
                fin <= 1'b1; state <= S_EMIT;
              end else idx <= idx + 1'b1;
            end
          end else if (idx == LastIdx) begin
            // empty list reports not found
            if (!pend) st <= mrt_pkg::ST_NOTFOUND;
            fin <= 1'b1; state <= S_EMIT;
          end else idx <= idx + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  initial_check: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data)) else $error("result changed while waiting");
  assert property (@(posedge clk) disable iff (rst)
    load |=> state == S_DISP) else $error("load did not start sequence");
  assert property (@(posedge clk) disable iff (rst)
    do_write |-> !in_ready) else $error("write while idle");
endmodule

>>> sim/tb.sv
// tb: self-checking testbench of the route table engine
// drives operations through the request channel, predicts each response
// depends on mrt_pkg, mrt_if and manet_route_table_engine_top
module tb;

  localparam int SLOTS = 16;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  mrt_req_if in_ch ();
  mrt_res_if out_ch ();

  manet_route_table_engine_top #(.TABLE_ENTRIES(SLOTS)) i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // predictor state
  logic [31:0] p_my_ip;
  logic [30:0] p_active;
  logic [30:0] p_delete;
  logic        t_used [SLOTS];
  logic        t_valid [SLOTS];
  logic        t_seqv [SLOTS];
  logic [31:0] t_dest [SLOTS];
  logic [31:0] t_nh [SLOTS];
  logic [31:0] t_seq [SLOTS];
  logic [7:0]  t_hops [SLOTS];
  logic [31:0] t_exp [SLOTS];
  logic [31:0] t_now;
  logic [31:0] t_own;

  mrt_pkg::res_t expected_responses [$];
  int   mismatches;
  bit   hold_off;

  // address pools keep lookups hitting the table
  logic [31:0] addr_pool [8];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic later(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

  function automatic void queue_resp(input mrt_pkg::res_t r);
    expected_responses = {expected_responses, r};
  endfunction

  function automatic int find_route(input logic [31:0] a);
    for (int i = 0; i < SLOTS; i++)
      if (t_used[i] && t_dest[i] == a) return i;
    return -1;
  endfunction

  function automatic int free_route();
    for (int i = 0; i < SLOTS; i++)
      if (!t_used[i]) return i;
    return -1;
  endfunction

  function automatic mrt_pkg::res_t make_response(input int idx, input logic [1:0] st,
                                                  input logic wr);
    mrt_pkg::res_t r;
    logic [31:0] left;
    r = '0;
    r.status = st;
    if (idx >= 0) begin
      left = t_exp[idx] - t_now;
      if (left == 32'd0 || left[31]) left = 32'd1;
      r.present = 1'b1;
      r.valid_res = t_valid[idx];
      r.seq_known = t_seqv[idx];
      r.out_dest = t_dest[idx];
      r.out_next_hop = t_nh[idx];
      r.out_seq = t_seq[idx];
      r.out_hops = t_hops[idx];
      r.life_left_ms = left[30:0];
    end
    r.own_seq = t_own;
    r.route_written = wr;
    return r;
  endfunction

  function automatic void write_entry(input int i, input mrt_pkg::req_t q,
                                      input logic [31:0] lt);
    t_used[i] = 1; t_valid[i] = 1;
    t_seqv[i] = (q.op == mrt_pkg::OP_UPD_SEQ);
    t_dest[i] = q.dest_addr;
    t_nh[i] = q.next_hop;
    t_seq[i] = (q.op == mrt_pkg::OP_UPD_SEQ) ? q.seq_num : 32'd0;
    t_hops[i] = q.hop_count;
    t_exp[i] = t_now + lt;
  endfunction

  function automatic void refresh_entry(input int i);
    logic [31:0] nx;
    nx = t_now + {1'b0, p_active};
    t_valid[i] = 1;
    if (later(nx, t_exp[i])) t_exp[i] = nx;
  endfunction

  // apply one operation to the table copy and queue its responses
  function automatic void predict_route_op(input mrt_pkg::req_t q);
    int idx, h, n;
    logic [31:0] lt, nx;
    mrt_pkg::res_t r;
    n = 0;
    case (q.op)
      mrt_pkg::OP_UPD_NOSEQ, mrt_pkg::OP_UPD_SEQ: begin
        lt = (q.op == mrt_pkg::OP_UPD_SEQ && q.lifetime_ms != 0) ? {1'b0, q.lifetime_ms}
                                                                  : {1'b0, p_active};
        if (q.dest_addr == p_my_ip || q.next_hop == p_my_ip) begin
          r = make_response(-1, mrt_pkg::ST_NOTFOUND, 0);
        end else begin
          idx = find_route(q.dest_addr);
          if (idx < 0) begin
            idx = free_route();
            if (idx < 0) r = make_response(-1, mrt_pkg::ST_FULL, 0);
            else begin
              write_entry(idx, q, lt);
              r = make_response(idx, mrt_pkg::ST_OK, 1);
            end
          end else if (q.op == mrt_pkg::OP_UPD_NOSEQ || !t_valid[idx] ||
                       later(q.seq_num, t_seq[idx]) ||
                       (q.seq_num == t_seq[idx] && q.hop_count < t_hops[idx])) begin
            write_entry(idx, q, lt);
            r = make_response(idx, mrt_pkg::ST_OK, 1);
          end else begin
            r = make_response(idx, mrt_pkg::ST_OK, 0);
          end
        end
      end
      mrt_pkg::OP_LOOKUP, mrt_pkg::OP_ADD_LIFE, mrt_pkg::OP_RERR: begin
        idx = find_route(q.dest_addr);
        if (idx >= 0 && q.op == mrt_pkg::OP_ADD_LIFE) begin
          nx = t_now + {1'b0, q.lifetime_ms};
          if (later(nx, t_exp[idx])) t_exp[idx] = nx;
        end else if (idx >= 0 && q.op == mrt_pkg::OP_RERR) begin
          if (t_valid[idx]) t_seq[idx] += 1;
          t_valid[idx] = 0;
          t_exp[idx] = t_now + {1'b0, p_delete};
        end
        r = make_response(idx, idx >= 0 ? mrt_pkg::ST_OK : mrt_pkg::ST_NOTFOUND, 0);
      end
      mrt_pkg::OP_USED: begin
        if (q.source_addr != p_my_ip) begin
          idx = find_route(q.source_addr);
          if (idx >= 0) refresh_entry(idx);
        end
        idx = find_route(q.dest_addr);
        if (idx >= 0) begin
          refresh_entry(idx);
          h = find_route(t_nh[idx]);
          if (h >= 0) refresh_entry(h);
        end
        r = make_response(idx, idx >= 0 ? mrt_pkg::ST_OK : mrt_pkg::ST_NOTFOUND, 0);
      end
      mrt_pkg::OP_TICK: begin
        t_now += 1;
        for (int i = 0; i < SLOTS; i++)
          if (t_used[i] && !later(t_exp[i], t_now)) begin
            if (t_valid[i]) begin
              t_valid[i] = 0;
              t_exp[i] = t_now + {1'b0, p_delete};
            end else t_used[i] = 0;
          end
        r = make_response(-1, mrt_pkg::ST_OK, 0);
      end
      mrt_pkg::OP_INC_OWN, mrt_pkg::OP_UPD_OWN: begin
        if (q.op == mrt_pkg::OP_INC_OWN) t_own += 1;
        else if (!later(t_own, q.seq_num)) t_own = q.seq_num;
        r = make_response(-1, mrt_pkg::ST_OK, 0);
      end
      mrt_pkg::OP_BY_NH: begin
        // every match but the final one is queued here
        for (int i = 0; i < SLOTS && n < mrt_pkg::MAX_RESULTS; i++)
          if (t_used[i] && t_valid[i] && t_nh[i] == q.next_hop) begin
            if (n > 0) queue_resp(r);
            r = make_response(i, mrt_pkg::ST_OK, 0);
            n++;
          end
        if (n == 0) r = make_response(-1, mrt_pkg::ST_NOTFOUND, 0);
      end
      default: r = make_response(-1, mrt_pkg::ST_OK, 0);
    endcase
    r.last = 1'b1;
    queue_resp(r);
  endfunction

  // send one operation, predicting at its transfer, then idle a drawn gap
  task automatic send_op(input mrt_pkg::req_t q);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data <= q;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_route_op(q);
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for all responses, then let the engine settle
  task automatic drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (expected_responses.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mrt_pkg::CFG_MY_IP:  p_my_ip = val;
      mrt_pkg::CFG_ACTIVE: p_active = val[30:0];
      mrt_pkg::CFG_DELETE: p_delete = val[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic mrt_pkg::req_t base_op(input logic [3:0] op);
    mrt_pkg::req_t q;
    q.op = op;
    q.dest_addr = addr_pool[$urandom_range(0, 7)];
    q.source_addr = addr_pool[$urandom_range(0, 7)];
    q.next_hop = addr_pool[$urandom_range(0, 3)];
    q.seq_num = $urandom_range(0, 6);
    q.hop_count = 8'($urandom_range(0, 5));
    q.lifetime_ms = 31'($urandom_range(0, 8));
    return q;
  endfunction

  // response receiver: draws a wait after each transfer, holds off on request
  initial begin
    int wait_left;
    wait_left = 0;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) wait_left = $urandom_range(0, 10);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (wait_left > 0) begin
        out_ch.ready <= 1'b0;
        wait_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // response checker
  initial begin
    mrt_pkg::res_t want;
    mrt_pkg::res_t got;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response: expected none actual %h", got);
        end else begin
          want = expected_responses.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response mismatch: expected %h actual %h", want, got);
          end
        end
      end
    end
  end

  task automatic test_directed_ops();
    mrt_pkg::req_t q;
    write_reg(mrt_pkg::CFG_MY_IP, 32'h0000_0001);
    write_reg(mrt_pkg::CFG_ACTIVE, 32'd3);
    write_reg(mrt_pkg::CFG_DELETE, 32'd2);
    // insert, lookups and sequence rules
    q = base_op(mrt_pkg::OP_UPD_NOSEQ); q.dest_addr = 32'hFFFF_FFFF; q.next_hop = 32'h10;
    q.hop_count = 8'hFF; send_op(q);
    q = base_op(mrt_pkg::OP_UPD_SEQ); q.dest_addr = addr_pool[0]; q.next_hop = addr_pool[1];
    q.seq_num = 32'hFFFF_FFFF; q.hop_count = 3; q.lifetime_ms = 0; send_op(q);
    q.seq_num = 32'hFFFF_FFFF; q.hop_count = 2; q.lifetime_ms = 31'h7FFF_FFFF; send_op(q);
    q.seq_num = 32'h0000_0000; send_op(q);
    q.seq_num = 32'h8000_0000; q.hop_count = 9; send_op(q);
    q = base_op(mrt_pkg::OP_UPD_SEQ); q.dest_addr = 32'h1; send_op(q);
    q = base_op(mrt_pkg::OP_UPD_SEQ); q.next_hop = 32'h1; send_op(q);
    q = base_op(mrt_pkg::OP_LOOKUP); q.dest_addr = 32'hDEAD_0000; send_op(q);
    q = base_op(mrt_pkg::OP_LOOKUP); q.dest_addr = addr_pool[0]; send_op(q);
    q = base_op(mrt_pkg::OP_ADD_LIFE); q.dest_addr = addr_pool[0]; q.lifetime_ms = 0;
    send_op(q);
    q.lifetime_ms = 31'h7FFF_FFFF; send_op(q);
    q = base_op(mrt_pkg::OP_USED); q.dest_addr = addr_pool[0]; q.source_addr = 32'hFFFF_FFFF;
    send_op(q);
    q = base_op(mrt_pkg::OP_RERR); q.dest_addr = addr_pool[0]; send_op(q); send_op(q);
    q = base_op(mrt_pkg::OP_BY_NH); q.next_hop = 32'h10; send_op(q);
    q.next_hop = 32'h5555_5555; send_op(q);
    q = base_op(mrt_pkg::OP_INC_OWN); send_op(q);
    q = base_op(mrt_pkg::OP_UPD_OWN); q.seq_num = 32'hFFFF_FFFF; send_op(q);
    q.seq_num = 32'h7FFF_FFFF; send_op(q);
    q.op = 4'd15; send_op(q);
    q.op = 4'd10; send_op(q);
    // ticks expire, then free the short-lived entries
    repeat (4) send_op(base_op(mrt_pkg::OP_TICK));
    drain();
  endtask

  task automatic test_full_table();
    mrt_pkg::req_t q;
    // fill every slot with one shared next hop, then overflow
    for (int i = 0; i < SLOTS + 2; i++) begin
      q = base_op(mrt_pkg::OP_UPD_NOSEQ);
      q.dest_addr = 32'(32'hA000_0000 + i);
      q.next_hop = 32'h0000_0077;
      send_op(q);
    end
    q = base_op(mrt_pkg::OP_BY_NH); q.next_hop = 32'h0000_0077; send_op(q);
    drain();
    write_reg(mrt_pkg::CFG_ACTIVE, 32'd1);
    write_reg(mrt_pkg::CFG_DELETE, 32'd1);
    repeat (3) send_op(base_op(mrt_pkg::OP_TICK));
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) begin
        send_op(base_op(mrt_pkg::OP_UPD_NOSEQ));
      end
    join
    drain();
  endtask

  task automatic test_random_ops(input int count, input logic [31:0] act,
                                 input logic [31:0] del);
    mrt_pkg::req_t q;
    int pick;
    write_reg(mrt_pkg::CFG_MY_IP, $urandom());
    write_reg(mrt_pkg::CFG_ACTIVE, act);
    write_reg(mrt_pkg::CFG_DELETE, del);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) q = base_op(4'($urandom_range(0, 1)));
      else if (pick < 40) q = base_op(mrt_pkg::OP_TICK);
      else if (pick < 90) q = base_op(4'($urandom_range(2, 9)));
      else begin
        q = base_op(4'($urandom_range(0, 15)));
        q.dest_addr = $urandom(); q.source_addr = $urandom();
        q.next_hop = $urandom(); q.seq_num = $urandom();
        q.hop_count = 8'($urandom()); q.lifetime_ms = 31'($urandom());
      end
      send_op(q);
    end
    drain();
  endtask

  initial begin
    mismatches = 0;
    hold_off = 1'b0;
    expected_responses = {};
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_idx <= mrt_pkg::CFG_MY_IP;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    p_my_ip = 0; p_active = 31'd3000; p_delete = 31'd15000;
    t_now = 0; t_own = 0;
    for (int i = 0; i < SLOTS; i++) begin
      t_used[i] = 0; t_valid[i] = 0; t_seqv[i] = 0; t_dest[i] = 0;
      t_nh[i] = 0; t_seq[i] = 0; t_hops[i] = 0; t_exp[i] = 0;
    end
    for (int i = 0; i < 8; i++) addr_pool[i] = 32'(32'h0A00_0010 + i);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_ops();
    test_full_table();
    test_backpressure();
    test_random_ops(40, 32'd4, 32'd3);
    test_random_ops(40, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    test_random_ops(40, 32'd1, 32'd1);
    if (mismatches == 0 && expected_responses.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
